>>> rtl/core/sida_pkg.sv
// Shared types and codes for the shift insert/delete array.
// No dependencies; imported by the cell and the top level.
`default_nettype none

package sida_pkg;

  typedef enum logic [2:0] {
    MODE_INS_POS   = 3'd0,
    MODE_INS_START = 3'd1,
    MODE_INS_END   = 3'd2,
    MODE_DEL_POS   = 3'd3,
    MODE_DEL_START = 3'd4,
    MODE_DEL_END   = 3'd5,
    MODE_READ      = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Command broadcast to every cell of the row for one accepted request.
  typedef struct packed {
    logic ins;  // insert succeeds: cells at and above the position move up
    logic del;  // delete succeeds: cells at and above the position move down
  } shift_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/sida_cell.sv
// One storage cell of the array row, holding a single word.
// Depends on sida_pkg for the broadcast shift command.
`default_nettype none

module sida_cell #(
  parameter int INDEX     = 0,
  parameter int AT_W      = 6,
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire sida_pkg::shift_ctrl_t ctrl,
  input  wire logic [AT_W-1:0]       at,
  input  wire logic [WORD_BITS-1:0]  new_word,
  input  wire logic [WORD_BITS-1:0]  left_word,
  input  wire logic [WORD_BITS-1:0]  right_word,
  output logic      [WORD_BITS-1:0]  word,
  output logic                       hit
);
  import sida_pkg::*;

  localparam logic [AT_W-1:0] MY_INDEX = AT_W'(INDEX);

  logic                 above;
  logic [WORD_BITS-1:0] word_next;

  assign hit   = (at == MY_INDEX);
  assign above = (MY_INDEX > at);

  always_comb begin
    word_next = word;
    if (ctrl.ins) begin
      if (hit) begin
        word_next = new_word;
      end else if (above) begin
        word_next = left_word;
      end
    end else if (ctrl.del) begin
      if (hit || above) begin
        word_next = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/shift_insert_delete_array_core.sv
// Top level of the shift insert/delete array: status decode, cell row, result register.
// Depends on sida_pkg and sida_cell.
`default_nettype none

// Channel   Direction  Handshake          Payload
// request   in         in_valid/in_stall  mode, position, value_in
// result    out        out_valid/out_stall status, count_out, value_out
//
// Every request is handled at its accepting edge: all cells shift in parallel and the result
// is loaded into the output register, so one request per cycle while the result side does not stall.
// The removed or read word is picked by the cell whose index matches the target index.
// Reset clears the fill count and the result valid; cell contents stay undefined
// until written, and no request ever reads beyond the fill count.
// A request is held off only while a result waits and the far side stalls.

module shift_insert_delete_array_core #(
  parameter int CAPACITY  = 32,
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [5:0]  position,
  input  wire logic [31:0] value_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [5:0]       count_out,
  output logic [31:0]      value_out
);
  import sida_pkg::*;

  // Width of the fill count, and of the comparisons that mix it with position.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic             accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] at;
  status_t          st;
  logic             is_ins;
  logic             is_take;
  logic             full;
  logic             empty;
  shift_ctrl_t      ctrl;

  logic [63:0]          vin64;
  logic [WORD_BITS-1:0] new_word;

  logic [CAPACITY-1:0][WORD_BITS-1:0] cell_word;
  logic [CAPACITY-1:0]                cell_hit;
  logic [WORD_BITS-1:0]               picked;
  logic [63:0]                        picked64;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(cnt);
  assign full    = (cnt == CAP_CNT);
  assign empty   = (cnt == '0);

  // Stored words keep the low WORD_BITS bits of the unsigned input word.
  assign vin64    = {32'd0, value_in};
  assign new_word = vin64[WORD_BITS-1:0];

  // Decode the request: target index, and whether it succeeds. The full and
  // empty checks take priority over the position check.
  always_comb begin
    at      = '0;
    st      = ST_RANGE;
    is_ins  = 1'b0;
    is_take = 1'b0;
    case (mode)
      MODE_INS_POS: begin
        at     = pos_ext;
        is_ins = 1'b1;
        st     = full ? ST_FULL : ((pos_ext > cnt_ext) ? ST_RANGE : ST_OK);
      end
      MODE_INS_START: begin
        at     = '0;
        is_ins = 1'b1;
        st     = full ? ST_FULL : ST_OK;
      end
      MODE_INS_END: begin
        at     = cnt_ext;
        is_ins = 1'b1;
        st     = full ? ST_FULL : ST_OK;
      end
      MODE_DEL_POS: begin
        at      = pos_ext;
        is_take = 1'b1;
        st      = empty ? ST_EMPTY : ((pos_ext >= cnt_ext) ? ST_RANGE : ST_OK);
      end
      MODE_DEL_START: begin
        at      = '0;
        is_take = 1'b1;
        st      = empty ? ST_EMPTY : ST_OK;
      end
      MODE_DEL_END: begin
        at      = cnt_ext - CMP_W'(1);
        is_take = 1'b1;
        st      = empty ? ST_EMPTY : ST_OK;
      end
      MODE_READ: begin
        at = pos_ext;
        st = (pos_ext < cnt_ext) ? ST_OK : ST_RANGE;
      end
      default: begin
        st = ST_RANGE;
      end
    endcase
  end

  assign ctrl.ins = accept && is_ins && (st == ST_OK);
  assign ctrl.del = accept && is_take && (st == ST_OK);

  always_comb begin
    cnt_next = cnt;
    if (ctrl.ins) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (ctrl.del) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  // The row of cells. On insert the cells above the target take their left neighbor and the
  // target cell the new word; on delete the cells at and above it take their right neighbor; the ends see zero words.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    sida_cell #(
      .INDEX     (i),
      .AT_W      (CMP_W),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .at         (at),
      .new_word   (new_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .hit        (cell_hit[i])
    );
  end

  // At most one cell matches the target index, so an AND-OR picks its word.
  always_comb begin
    picked = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      picked = picked | (cell_word[k] & {WORD_BITS{cell_hit[k]}});
    end
  end

  assign picked64 = 64'(picked);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; a failed request or a successful insert returns a zero word.
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= st;
      count_out <= 6'(cnt_next);
      value_out <= ((st == ST_OK) && (mode != MODE_INS_POS) && (mode != MODE_INS_START)
                    && (mode != MODE_INS_END)) ? picked64[31:0] : 32'd0;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_CNT)
    else $error("fill count exceeds capacity");

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_hit))
    else $error("more than one cell matches the target index");

  a_fail_keeps_cnt: assert property (@(posedge clk) disable iff (rst)
    accept && (st != ST_OK) |=> cnt == $past(cnt))
    else $error("failed request changed the fill count");

  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && (count_out == 6'($past(cnt_next))))
    else $error("accepted request did not load a result");
`endif

endmodule

`default_nettype wire

>>> dv/shift_insert_delete_array_checker.sv
// Checker for the shift insert/delete array: watches both channels, keeps its own copy of the
// list, predicts one result per accepted request and compares every accepted result.
// Depends on sida_pkg for the mode and status codes.
module shift_insert_delete_array_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [5:0]  position,
  input  logic [31:0] value_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [5:0]  count_out,
  input  logic [31:0] value_out,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sida_pkg::*;

  localparam int CAPACITY = 32;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t     st;
    logic [5:0]  count;
    logic [31:0] word;
  } outcome_t;

  logic [31:0] slots [CAPACITY];
  int unsigned fill;
  outcome_t    expected_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic status_t shift_in(input int unsigned at, input logic [31:0] w);
    if (fill >= CAPACITY) return ST_FULL;
    if (at > fill) return ST_RANGE;
    for (int unsigned j = fill; j > at; j--) slots[j] = slots[j - 1];
    slots[at] = w;
    fill++;
    return ST_OK;
  endfunction

  function automatic status_t shift_out(input int unsigned at, output logic [31:0] w);
    w = '0;
    if (fill == 0) return ST_EMPTY;
    if (at >= fill) return ST_RANGE;
    w = slots[at];
    for (int unsigned j = at; j + 1 < fill; j++) slots[j] = slots[j + 1];
    fill--;
    return ST_OK;
  endfunction

  // Applies one request to the local list and returns the result the block must give.
  function automatic outcome_t apply_request(input logic [2:0] op, input logic [5:0] pos,
                                             input logic [31:0] w);
    outcome_t    res;
    logic [31:0] taken;
    taken = '0;
    case (op)
      MODE_INS_POS:   res.st = shift_in(pos, w);
      MODE_INS_START: res.st = shift_in(0, w);
      MODE_INS_END:   res.st = shift_in(fill, w);
      MODE_DEL_POS:   res.st = shift_out(pos, taken);
      MODE_DEL_START: res.st = shift_out(0, taken);
      MODE_DEL_END:   res.st = shift_out((fill == 0) ? 0 : fill - 1, taken);
      MODE_READ: begin
        if (pos < fill) begin
          taken = slots[pos];
          res.st = ST_OK;
        end else begin
          res.st = ST_RANGE;
        end
      end
      default:        res.st = ST_RANGE;
    endcase
    res.count = 6'(fill);
    res.word = (res.st == ST_OK) ? taken : '0;
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t seen;
    if (rst) begin
      fill = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      seen.st = status_t'(status);
      seen.count = count_out;
      seen.word = value_out;
      // Results leave before the new request is predicted, since the block's result is registered.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with nothing expected: status %0d count %0d value %h",
                                 seen.st, seen.count, seen.word));
        end else begin
          want = expected_results.pop_front();
          if (seen.st !== want.st || seen.count !== want.count || seen.word !== want.word) begin
            note_failure($sformatf({"result mismatch: expected status %0d count %0d value %h,",
                                    " got status %0d count %0d value %h"},
                                   want.st, want.count, want.word,
                                   status, count_out, value_out));
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_request(mode, position,
                                                                          value_in));
      pending <= expected_results.size();
    end
  end

endmodule

>>> dv/testbench.sv
// Top of the shift insert/delete array bench: clock, reset, request stimulus, result stalls,
// a no-progress watchdog and the verdict. Depends on sida_pkg, the core and the checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sida_pkg::*;

  localparam int CAPACITY = 32;
  localparam logic [2:0] MODE_UNUSED = 3'd7;  // the one mode code the block does not define
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES = 80;     // long receiver hold-off, well under the watchdog limit
  localparam int STALL_LIMIT = 1000;   // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 8;     // idle time at the end; the block's result is registered
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [2:0]  mode = MODE_READ;
  logic [5:0]  position = '0;
  logic [31:0] value_in = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  status;
  logic [5:0]  count_out;
  logic [31:0] value_out;
  int          fail_count;
  int          pending;

  // Stimulus controls shared with the receiver process.
  bit quiet = 1'b0;          // no idling on either side while set
  bit hold_off_req = 1'b0;   // asks the receiver for one long hold-off
  int level = 0;             // list length the accepted requests should have produced

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shift_insert_delete_array_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .position  (position),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .count_out (count_out),
    .value_out (value_out)
  );

  shift_insert_delete_array_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .position   (position),
    .value_in   (value_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .count_out  (count_out),
    .value_out  (value_out),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The stimulus only needs the list length to aim positions near the valid range, so it
  // tracks whether each request should succeed, not the stored words.
  function automatic int next_level(input logic [2:0] op, input logic [5:0] pos, input int lv);
    case (op)
      MODE_INS_POS:                 return (lv < CAPACITY && pos <= lv) ? lv + 1 : lv;
      MODE_INS_START, MODE_INS_END: return (lv < CAPACITY) ? lv + 1 : lv;
      MODE_DEL_POS:                 return (pos < lv) ? lv - 1 : lv;
      MODE_DEL_START, MODE_DEL_END: return (lv > 0) ? lv - 1 : lv;
      default:                      return lv;
    endcase
  endfunction

  // Offers one request and holds it until it is accepted. Valid stays high when the next
  // request follows at once; otherwise it drops for a short random gap.
  task automatic send(input logic [2:0] op, input logic [5:0] pos, input logic [31:0] w);
    in_valid <= 1'b1;
    mode <= op;
    position <= pos;
    value_in <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    level = next_level(op, pos, level);
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stops offering requests until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: random stalls with a 13 percent chance, none while quiet, and one
  // long hold-off on request so the output register fills and the request side backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 13);
      end
    end
  end

  // Watchdog: any accepted request or result resets the count of idle cycles.
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("[shift_insert_delete_array_core] ERROR");
    $finish;
  end

  initial begin
    int          kind;
    int          pick;
    logic [2:0]  op;
    logic [5:0]  pos;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part. On an empty list every removal reports empty, while a read and the
    // unused mode report a bad position.
    send(MODE_READ, 6'd0, 32'h0);
    send(MODE_DEL_POS, 6'd0, 32'h0);
    send(MODE_DEL_START, 6'd0, 32'h0);
    send(MODE_DEL_END, 6'd0, 32'h0);
    send(MODE_UNUSED, 6'd0, 32'h0);
    // Inserting past the count fails; inserting exactly at the count appends.
    send(MODE_INS_POS, 6'd1, 32'h1234_5678);
    send(MODE_INS_POS, 6'd0, 32'h8000_0000);
    send(MODE_INS_START, 6'd0, 32'h7fff_ffff);
    send(MODE_INS_END, 6'd0, 32'hffff_ffff);
    send(MODE_INS_POS, 6'd3, 32'h0000_0000);
    send(MODE_INS_POS, 6'd63, 32'hdead_beef);
    send(MODE_INS_POS, 6'd1, 32'h5555_aaaa);
    // Reads at both ends of the list, then at and far beyond the count.
    send(MODE_READ, 6'd0, 32'h0);
    send(MODE_READ, 6'd4, 32'h0);
    send(MODE_READ, 6'd5, 32'h0);
    send(MODE_READ, 6'd63, 32'h0);
    // Deletes: out of range first, then from the middle, the start and the end.
    send(MODE_DEL_POS, 6'd5, 32'h0);
    send(MODE_DEL_POS, 6'd63, 32'h0);
    send(MODE_DEL_POS, 6'd2, 32'h0);
    send(MODE_DEL_START, 6'd0, 32'h0);
    send(MODE_DEL_END, 6'd0, 32'h0);
    send(MODE_UNUSED, 6'd1, 32'hffff_ffff);
    send(MODE_READ, 6'd1, 32'h0);
    wait_drained();

    // Random part in phases that fill, drain or churn the list, so that full and empty are
    // both reached often. Positions mostly fall inside the valid range; a few requests are
    // noise with any mode and any position.
    for (int phase = 0; phase < PHASES; phase++) begin
      kind = phase % 3;
      if (phase == 2) hold_off_req = 1'b1;
      quiet = (phase == 4);
      if (phase == 7) wait_drained();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          op = 3'($urandom_range(0, 7));
          pos = 6'($urandom_range(0, 63));
        end else begin
          pick = $urandom_range(99);
          if (pick < ((kind == 0) ? 70 : (kind == 1) ? 20 : 40)) begin
            op = 3'(MODE_INS_POS + $urandom_range(0, 2));
            pos = 6'($urandom_range(0, level));
          end else if (pick < ((kind == 2) ? 75 : 85)) begin
            op = 3'(MODE_DEL_POS + $urandom_range(0, 2));
            pos = (level == 0) ? 6'd0 : 6'($urandom_range(0, level - 1));
          end else begin
            op = MODE_READ;
            pos = (level == 0) ? 6'd0 : 6'($urandom_range(0, level - 1));
          end
        end
        send(op, pos, $urandom());
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[shift_insert_delete_array_core] OK");
    end else begin
      $display("[shift_insert_delete_array_core] ERROR");
    end
    $finish;
  end

endmodule
